// ===== src/pressure_temp_compensation_assert.svh =====
// assertion macros shared by the compensation pipeline
`ifndef PRESSURE_TEMP_COMPENSATION_ASSERT_SVH
`define PRESSURE_TEMP_COMPENSATION_ASSERT_SVH

// same-cycle implication
`define PTC_ASSERT_IMPL(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PTC_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ptc_pkg.sv =====
`default_nettype none

package ptc_pkg;

  localparam int UT_W       = 16;
  localparam int UPB_W      = 24;
  localparam int UP_W       = 19;
  localparam int T_W        = 16;
  localparam int P_W        = 18;
  localparam int X1_W       = 18;
  localparam int D1N_W      = 27;
  localparam int D1D_W      = 18;
  localparam int D2N_W      = 50;
  localparam int D2D_W      = 35;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam int K_T_OFF  = 4000;
  localparam int K_B7     = 50000;
  localparam int K_X1     = 3038;
  localparam int K_X2     = -7357;
  localparam int K_COR    = 3791;
  localparam int K_B4_OFF = 32768;
  localparam logic [P_W-1:0] P_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AC_FIRST  = 3'd0,
    CFG_AC_SECOND = 3'd1,
    CFG_B_PAIR    = 3'd2,
    CFG_M_PAIR    = 3'd3,
    CFG_OSS       = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [15:0] ac1;
    logic signed [15:0] ac2;
    logic signed [15:0] ac3;
    logic [15:0]        ac4;
    logic [15:0]        ac5;
    logic [15:0]        ac6;
    logic signed [15:0] b1;
    logic signed [15:0] b2;
    logic signed [15:0] mc;
    logic signed [15:0] md;
    logic [1:0]         oss;
  } cal_t;

  typedef struct packed {
    logic                  fault;
    logic                  qneg;
    logic signed [X1_W-1:0] x1;
    logic [UP_W-1:0]       up;
  } side1_t;

  typedef struct packed {
    logic                  fault;
    logic                  qneg;
    logic signed [T_W-1:0] temp;
  } side2_t;

endpackage

`default_nettype wire

// ===== src/ptc_if.sv =====
`default_nettype none

interface ptc_in_if;
  logic                        valid;
  logic                        ready;
  logic [ptc_pkg::UT_W-1:0]    raw_temperature;
  logic [ptc_pkg::UPB_W-1:0]   raw_pressure_bytes;
  modport source (output valid, raw_temperature, raw_pressure_bytes, input ready);
  modport sink (input valid, raw_temperature, raw_pressure_bytes, output ready);
endinterface

interface ptc_out_if;
  logic                        valid;
  logic                        ready;
  logic signed [ptc_pkg::T_W-1:0] temperature_decideg;
  logic [ptc_pkg::P_W-1:0]     pressure_pa;
  logic                        divide_fault;
  modport source (output valid, temperature_decideg, pressure_pa, divide_fault, input ready);
  modport sink (input valid, temperature_decideg, pressure_pa, divide_fault, output ready);
endinterface

interface ptc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ptc_pkg::CFG_IDX_W-1:0]  index;
  logic [ptc_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/ptc_div.sv =====
`default_nettype none

`include "pressure_temp_compensation_assert.svh"

module ptc_div #(
  parameter int NW    = 27,
  parameter int DW    = 18,
  parameter int SW    = 8,
  parameter int STEPS = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          up_valid_i,
  output logic          up_ready_o,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  input  logic [SW-1:0] side_i,
  output logic          dn_valid_o,
  input  logic          dn_ready_i,
  output logic [NW-1:0] quotient_o,
  output logic [SW-1:0] side_o
);

  localparam int NS = (NW + STEPS - 1) / STEPS;

  logic          v_q   [NS];
  logic          en    [NS];
  logic [DW-1:0] rem_q [NS];
  logic [NW-1:0] qn_q  [NS];
  logic [DW-1:0] dv_q  [NS];
  logic [SW-1:0] sd_q  [NS];

  genvar k;
  for (k = 0; k < NS; k++) begin : g_st
    logic          v_in;
    logic [DW-1:0] rem_in;
    logic [NW-1:0] qn_in;
    logic [DW-1:0] dv_in;
    logic [SW-1:0] sd_in;
    logic [DW-1:0] rem_d;
    logic [NW-1:0] qn_d;

    if (k == 0) begin : g_first
      assign v_in   = up_valid_i;
      assign rem_in = '0;
      assign qn_in  = dividend_i;
      assign dv_in  = divisor_i;
      assign sd_in  = side_i;
    end else begin : g_next
      assign v_in   = v_q[k-1];
      assign rem_in = rem_q[k-1];
      assign qn_in  = qn_q[k-1];
      assign dv_in  = dv_q[k-1];
      assign sd_in  = sd_q[k-1];
    end

    if (k == NS - 1) begin : g_last
      assign en[k] = !v_q[k] | dn_ready_i;
    end else begin : g_mid
      assign en[k] = !v_q[k] | en[k+1];
    end

    // restoring division, msb first
    always_comb begin
      logic [DW:0] trial;
      logic [DW:0] diff;
      rem_d = rem_in;
      qn_d  = qn_in;
      for (int j = 0; j < STEPS; j++) begin
        if (k * STEPS + j < NW) begin
          trial = {rem_d, qn_d[NW-1]};
          diff  = trial - {1'b0, dv_in};
          if (trial >= {1'b0, dv_in}) begin
            rem_d = diff[DW-1:0];
            qn_d  = {qn_d[NW-2:0], 1'b1};
          end else begin
            rem_d = trial[DW-1:0];
            qn_d  = {qn_d[NW-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        rem_q[k] <= rem_d;
        qn_q[k]  <= qn_d;
        dv_q[k]  <= dv_in;
        sd_q[k]  <= sd_in;
      end
    end
  end

  assign up_ready_o = en[0];
  assign dn_valid_o = v_q[NS-1];
  assign quotient_o = qn_q[NS-1];
  assign side_o     = sd_q[NS-1];

  `PTC_ASSERT_IMPL(a_rem_below_divisor, clk_i, rst_ni, v_q[NS-1], rem_q[NS-1] < dv_q[NS-1], "divider remainder not below divisor")
  `PTC_ASSERT_IMPL(a_ready_follows, clk_i, rst_ni, dn_ready_i, up_ready_o, "divider blocks input while output drains")

endmodule

`default_nettype wire

// ===== src/ptc_front.sv =====
`default_nettype none

module ptc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ptc_pkg::cal_t                 cal_i,
  input  logic                          up_valid_i,
  output logic                          up_ready_o,
  input  logic [ptc_pkg::UT_W-1:0]      ut_i,
  input  logic [ptc_pkg::UPB_W-1:0]     upb_i,
  output logic                          dn_valid_o,
  input  logic                          dn_ready_i,
  output logic [ptc_pkg::D1N_W-1:0]     dividend_o,
  output logic [ptc_pkg::D1D_W-1:0]     divisor_o,
  output ptc_pkg::side1_t               side_o
);

  logic v_q [3];
  logic en  [3];

  assign en[2] = !v_q[2] | dn_ready_i;
  assign en[1] = !v_q[1] | en[2];
  assign en[0] = !v_q[0] | en[1];

  // stage 0: ut - ac6, pressure alignment
  logic signed [16:0]            d_d, d_q;
  logic [ptc_pkg::UPB_W-1:0]     up_sh;
  logic [ptc_pkg::UP_W-1:0]      up0_q, up1_q, up2_q;

  assign d_d   = $signed({1'b0, ut_i}) - $signed({1'b0, cal_i.ac6});
  assign up_sh = upb_i >> (4'd8 - {2'b00, cal_i.oss});

  // stage 1: x1
  logic signed [33:0]              prod;
  logic signed [ptc_pkg::X1_W-1:0] x1_d, x1_q, x1_2_q;

  assign prod = d_q * $signed({1'b0, cal_i.ac5});
  assign x1_d = prod[32:15];

  // stage 2: denominator and magnitudes
  logic signed [18:0]              den, den_neg;
  logic [ptc_pkg::D1D_W-1:0]       den_mag;
  logic [15:0]                     mc_mag;
  logic                            fault_q, qneg_q;
  logic [ptc_pkg::D1N_W-1:0]       dividend_q;
  logic [ptc_pkg::D1D_W-1:0]       divisor_q;

  assign den     = $signed({x1_q[17], x1_q}) + $signed({{3{cal_i.md[15]}}, cal_i.md});
  assign den_neg = -den;
  assign den_mag = den[18] ? den_neg[17:0] : den[17:0];
  assign mc_mag  = cal_i.mc[15] ? (16'd0 - cal_i.mc) : cal_i.mc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
      v_q[1] <= 1'b0;
      v_q[2] <= 1'b0;
    end else begin
      if (en[0]) v_q[0] <= up_valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      d_q   <= d_d;
      up0_q <= up_sh[ptc_pkg::UP_W-1:0];
    end
    if (en[1]) begin
      x1_q  <= x1_d;
      up1_q <= up0_q;
    end
    if (en[2]) begin
      x1_2_q     <= x1_q;
      up2_q      <= up1_q;
      fault_q    <= (den == '0);
      qneg_q     <= cal_i.mc[15] ^ den[18];
      dividend_q <= {mc_mag, 11'b0};
      divisor_q  <= (den == '0) ? ptc_pkg::D1D_W'(1) : den_mag;
    end
  end

  assign up_ready_o   = en[0];
  assign dn_valid_o   = v_q[2];
  assign dividend_o   = dividend_q;
  assign divisor_o    = divisor_q;
  assign side_o.fault = fault_q;
  assign side_o.qneg  = qneg_q;
  assign side_o.x1    = x1_2_q;
  assign side_o.up    = up2_q;

endmodule

`default_nettype wire

// ===== src/ptc_mid.sv =====
`default_nettype none

module ptc_mid (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ptc_pkg::cal_t                 cal_i,
  input  logic                          up_valid_i,
  output logic                          up_ready_o,
  input  logic [ptc_pkg::D1N_W-1:0]     q_i,
  input  ptc_pkg::side1_t               side_i,
  output logic                          dn_valid_o,
  input  logic                          dn_ready_i,
  output logic [ptc_pkg::D2N_W-1:0]     dividend_o,
  output logic [ptc_pkg::D2D_W-1:0]     divisor_o,
  output ptc_pkg::side2_t               side_o
);

  localparam int NST = 7;

  logic v_q [NST];
  logic en  [NST];

  assign en[NST-1] = !v_q[NST-1] | dn_ready_i;
  for (genvar k = 0; k < NST - 1; k++) begin : g_en
    assign en[k] = !v_q[k] | en[k+1];
  end

  logic                        fault_q [NST];
  logic [ptc_pkg::UP_W-1:0]    up_q    [5];
  logic signed [ptc_pkg::T_W-1:0] temp_q [6];

  // stage 0: b5, b6
  logic signed [27:0] qs, x2, b5_d, b6_d, b5_q, b6_q;
  assign qs   = $signed({1'b0, q_i});
  assign x2   = side_i.qneg ? -qs : qs;
  assign b5_d = $signed({{10{side_i.x1[17]}}, side_i.x1}) + x2;
  assign b6_d = b5_d - 28'(ptc_pkg::K_T_OFF);

  // stage 1: products of b6, temperature
  logic signed [55:0] sqp_d, sqp_q;
  logic signed [43:0] pa2_d, pa2_q, pa3_d, pa3_q;
  logic signed [23:0] t24;
  logic signed [15:0] temp_d;
  assign sqp_d = b6_q * b6_q;
  assign pa2_d = $signed(cal_i.ac2) * b6_q;
  assign pa3_d = $signed(cal_i.ac3) * b6_q;
  assign t24   = b5_q[27:4];

  always_comb begin
    if (t24 > 24'sd32767) begin
      temp_d = 16'sh7FFF;
    end else if (t24 < -24'sd32768) begin
      temp_d = 16'sh8000;
    end else begin
      temp_d = t24[15:0];
    end
  end

  // stage 2: second products
  logic signed [31:0] sq, x2a_q, x1c_q;
  logic signed [47:0] pb2_d, pb2_q, pb1_d, pb1_q;
  assign sq    = sqp_q[43:12];
  assign pb2_d = $signed(cal_i.b2) * sq;
  assign pb1_d = $signed(cal_i.b1) * sq;

  // stage 3: x3 sums, ac1 term
  logic signed [31:0] x1a, x3a, x2c, tb_d, tb_q, x3c_q;
  logic signed [33:0] s3;
  assign x1a  = pb2_q[42:11];
  assign x3a  = x1a + x2a_q;
  assign tb_d = $signed({{14{cal_i.ac1[15]}}, cal_i.ac1, 2'b00}) + x3a;
  assign x2c  = pb1_q[47:16];
  assign s3   = $signed({{2{x1c_q[31]}}, x1c_q}) + $signed({{2{x2c[31]}}, x2c}) + 34'sd2;

  // stage 4: b3, b4 product
  logic [31:0]        u;
  logic signed [32:0] v3, xs;
  logic signed [31:0] b3_d, b3_q;
  logic signed [49:0] b4p_d, b4p_q;
  assign u     = tb_q << cal_i.oss;
  assign v3    = $signed({u[31], u}) + 33'sd2;
  assign b3_d  = {v3[32], v3[32:2]};
  assign xs    = $signed({x3c_q[31], x3c_q}) + 33'(ptc_pkg::K_B4_OFF);
  assign b4p_d = $signed({1'b0, cal_i.ac4}) * xs;

  // stage 5: b4, b7
  logic signed [34:0] b4_q;
  logic signed [32:0] diff;
  logic [15:0]        kb7;
  logic signed [49:0] b7_d, b7_q;
  assign diff = $signed({14'b0, up_q[4]}) - $signed({b3_q[31], b3_q});
  assign kb7  = 16'(ptc_pkg::K_B7 >> cal_i.oss);
  assign b7_d = diff * $signed({1'b0, kb7});

  // stage 6: divider operands
  logic               b4z;
  logic signed [49:0] b7n;
  logic [49:0]        b7m;
  logic signed [34:0] b4n;
  logic [34:0]        b4m;
  logic [ptc_pkg::D2N_W-1:0] dividend_q;
  logic [ptc_pkg::D2D_W-1:0] divisor_q;
  logic               qneg_q;
  assign b4z = (b4_q == '0);
  assign b7n = -b7_q;
  assign b7m = b7_q[49] ? b7n : b7_q;
  assign b4n = -b4_q;
  assign b4m = b4_q[34] ? b4n : b4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NST; i++) begin
        v_q[i] <= 1'b0;
      end
    end else begin
      if (en[0]) v_q[0] <= up_valid_i;
      for (int i = 1; i < NST; i++) begin
        if (en[i]) v_q[i] <= v_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      b5_q       <= b5_d;
      b6_q       <= b6_d;
      up_q[0]    <= side_i.up;
      fault_q[0] <= side_i.fault;
    end
    if (en[1]) begin
      sqp_q      <= sqp_d;
      pa2_q      <= pa2_d;
      pa3_q      <= pa3_d;
      temp_q[0]  <= temp_d;
      up_q[1]    <= up_q[0];
      fault_q[1] <= fault_q[0];
    end
    if (en[2]) begin
      pb2_q      <= pb2_d;
      pb1_q      <= pb1_d;
      x2a_q      <= pa2_q[42:11];
      x1c_q      <= {pa3_q[43], pa3_q[43:13]};
      temp_q[1]  <= temp_q[0];
      up_q[2]    <= up_q[1];
      fault_q[2] <= fault_q[1];
    end
    if (en[3]) begin
      tb_q       <= tb_d;
      x3c_q      <= s3[33:2];
      temp_q[2]  <= temp_q[1];
      up_q[3]    <= up_q[2];
      fault_q[3] <= fault_q[2];
    end
    if (en[4]) begin
      b3_q       <= b3_d;
      b4p_q      <= b4p_d;
      temp_q[3]  <= temp_q[2];
      up_q[4]    <= up_q[3];
      fault_q[4] <= fault_q[3];
    end
    if (en[5]) begin
      b4_q       <= b4p_q[49:15];
      b7_q       <= b7_d;
      temp_q[4]  <= temp_q[3];
      fault_q[5] <= fault_q[4];
    end
    if (en[6]) begin
      dividend_q <= {b7m[48:0], 1'b0};
      divisor_q  <= b4z ? ptc_pkg::D2D_W'(1) : b4m;
      qneg_q     <= b7_q[49] ^ b4_q[34];
      temp_q[5]  <= temp_q[4];
      fault_q[6] <= fault_q[5] | b4z;
    end
  end

  assign up_ready_o   = en[0];
  assign dn_valid_o   = v_q[NST-1];
  assign dividend_o   = dividend_q;
  assign divisor_o    = divisor_q;
  assign side_o.fault = fault_q[6];
  assign side_o.qneg  = qneg_q;
  assign side_o.temp  = temp_q[5];

endmodule

`default_nettype wire

// ===== src/ptc_back.sv =====
`default_nettype none

module ptc_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           up_valid_i,
  output logic                           up_ready_o,
  input  logic [ptc_pkg::D2N_W-1:0]      q_i,
  input  ptc_pkg::side2_t                side_i,
  output logic                           dn_valid_o,
  input  logic                           dn_ready_i,
  output logic signed [ptc_pkg::T_W-1:0] temp_o,
  output logic [ptc_pkg::P_W-1:0]        pres_o,
  output logic                           fault_o
);

  localparam int NST = 5;
  localparam logic signed [13:0] KX2 = 14'(ptc_pkg::K_X2);

  logic v_q [NST];
  logic en  [NST];

  assign en[NST-1] = !v_q[NST-1] | dn_ready_i;
  for (genvar k = 0; k < NST - 1; k++) begin : g_en
    assign en[k] = !v_q[k] | en[k+1];
  end

  logic                           fault_q [NST-1];
  logic signed [ptc_pkg::T_W-1:0] temp_q  [NST-1];
  logic signed [31:0]             p_q     [NST-1];

  // stage 0: signed quotient saturated to 32 bits
  logic [ptc_pkg::D2N_W-1:0] nq;
  logic signed [31:0]        p_d;
  assign nq = '0 - q_i;

  always_comb begin
    if (side_i.qneg) begin
      if (q_i > ptc_pkg::D2N_W'(64'h8000_0000)) begin
        p_d = 32'sh8000_0000;
      end else begin
        p_d = nq[31:0];
      end
    end else if (q_i > ptc_pkg::D2N_W'(64'h7FFF_FFFF)) begin
      p_d = 32'sh7FFF_FFFF;
    end else begin
      p_d = q_i[31:0];
    end
  end

  // stage 1: squares and linear term
  logic signed [23:0] a;
  logic signed [47:0] aa_full;
  logic [46:0]        aa_q;
  logic signed [45:0] px_d, px_q;
  assign a       = p_q[0][31:8];
  assign aa_full = a * a;
  assign px_d    = p_q[0] * KX2;

  // stage 2: x1 and x2
  logic [58:0]        x1m;
  logic [41:0]        x1_q;
  logic signed [29:0] x2_q;
  assign x1m = 59'(aa_q) * 59'(ptc_pkg::K_X1);

  // stage 3: correction
  logic signed [43:0] s4;
  logic signed [39:0] corr_q;
  assign s4 = $signed({2'b00, x1_q}) + $signed({{14{x2_q[29]}}, x2_q})
              + 44'(ptc_pkg::K_COR);

  // stage 4: final pressure and output register
  logic signed [41:0]              pf;
  logic [ptc_pkg::P_W-1:0]         pres_d, pres_q;
  logic signed [ptc_pkg::T_W-1:0]  tout_q;
  logic                            fout_q;
  assign pf = $signed({{10{p_q[3][31]}}, p_q[3]}) + $signed({{2{corr_q[39]}}, corr_q});

  always_comb begin
    if (fault_q[3] || pf[41]) begin
      pres_d = '0;
    end else if (pf > $signed({24'b0, ptc_pkg::P_MAX})) begin
      pres_d = ptc_pkg::P_MAX;
    end else begin
      pres_d = pf[ptc_pkg::P_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NST; i++) begin
        v_q[i] <= 1'b0;
      end
    end else begin
      if (en[0]) v_q[0] <= up_valid_i;
      for (int i = 1; i < NST; i++) begin
        if (en[i]) v_q[i] <= v_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      p_q[0]     <= p_d;
      fault_q[0] <= side_i.fault;
      temp_q[0]  <= side_i.temp;
    end
    if (en[1]) begin
      aa_q       <= aa_full[46:0];
      px_q       <= px_d;
      p_q[1]     <= p_q[0];
      fault_q[1] <= fault_q[0];
      temp_q[1]  <= temp_q[0];
    end
    if (en[2]) begin
      x1_q       <= x1m[57:16];
      x2_q       <= px_q[45:16];
      p_q[2]     <= p_q[1];
      fault_q[2] <= fault_q[1];
      temp_q[2]  <= temp_q[1];
    end
    if (en[3]) begin
      corr_q     <= s4[43:4];
      p_q[3]     <= p_q[2];
      fault_q[3] <= fault_q[2];
      temp_q[3]  <= temp_q[2];
    end
    if (en[4]) begin
      pres_q <= pres_d;
      tout_q <= fault_q[3] ? '0 : temp_q[3];
      fout_q <= fault_q[3];
    end
  end

  assign up_ready_o = en[0];
  assign dn_valid_o = v_q[NST-1];
  assign temp_o     = tout_q;
  assign pres_o     = pres_q;
  assign fault_o    = fout_q;

endmodule

`default_nettype wire

// ===== src/pressure_temp_compensation.sv =====
// Barometric sensor compensation pipeline.
// in_i carries one raw reading per transaction: the 16-bit temperature word and
// the 24-bit pressure bytes. out_o returns one result per reading, in order:
// temperature in 0.1 degC, pressure in pascals saturated to 0..262143, and a
// fault flag that is set, with both values zero, when a divisor was zero.
// cfg_i writes the calibration registers by index; it is always ready. The user
// must write it only while no reading is in flight; the block does not enforce it.
// Each divider stage resolves DIV_STEPS quotient bits, two by default. The
// two restoring dividers set most of the pipeline depth; a new reading is
// taken every cycle unless a stall has filled every stage.
// Reset clears every stage valid and sets all calibration registers to zero.
// When the receiver stalls, each stage holds its data and bubbles ahead of it
// close up; in_i.ready drops only once every stage is occupied.
`default_nettype none

`include "pressure_temp_compensation_assert.svh"

module pressure_temp_compensation #(
  parameter int DIV_STEPS = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ptc_in_if.sink     in_i,
  ptc_out_if.source  out_o,
  ptc_cfg_if.sink    cfg_i
);

  logic [47:0]      ac_first_q, ac_second_q;
  logic [31:0]      b_pair_q, m_pair_q;
  logic [1:0]       oss_q;
  ptc_pkg::cal_t    cal;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ac_first_q  <= '0;
      ac_second_q <= '0;
      b_pair_q    <= '0;
      m_pair_q    <= '0;
      oss_q       <= '0;
    end else if (cfg_i.valid) begin
      unique case (ptc_pkg::cfg_idx_e'(cfg_i.index))
        ptc_pkg::CFG_AC_FIRST:  ac_first_q  <= cfg_i.data[47:0];
        ptc_pkg::CFG_AC_SECOND: ac_second_q <= cfg_i.data[47:0];
        ptc_pkg::CFG_B_PAIR:    b_pair_q    <= cfg_i.data[31:0];
        ptc_pkg::CFG_M_PAIR:    m_pair_q    <= cfg_i.data[31:0];
        ptc_pkg::CFG_OSS:       oss_q       <= cfg_i.data[1:0];
        default: ;
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;

  assign cal.ac1 = ac_first_q[47:32];
  assign cal.ac2 = ac_first_q[31:16];
  assign cal.ac3 = ac_first_q[15:0];
  assign cal.ac4 = ac_second_q[47:32];
  assign cal.ac5 = ac_second_q[31:16];
  assign cal.ac6 = ac_second_q[15:0];
  assign cal.b1  = b_pair_q[31:16];
  assign cal.b2  = b_pair_q[15:0];
  assign cal.mc  = m_pair_q[31:16];
  assign cal.md  = m_pair_q[15:0];
  assign cal.oss = oss_q;

  logic                          f_valid, f_ready;
  logic [ptc_pkg::D1N_W-1:0]     f_dividend;
  logic [ptc_pkg::D1D_W-1:0]     f_divisor;
  ptc_pkg::side1_t               f_side;

  logic                          d1_valid, d1_ready;
  logic [ptc_pkg::D1N_W-1:0]     d1_q;
  ptc_pkg::side1_t               d1_side;

  logic                          m_valid, m_ready;
  logic [ptc_pkg::D2N_W-1:0]     m_dividend;
  logic [ptc_pkg::D2D_W-1:0]     m_divisor;
  ptc_pkg::side2_t               m_side;

  logic                          d2_valid, d2_ready;
  logic [ptc_pkg::D2N_W-1:0]     d2_q;
  ptc_pkg::side2_t               d2_side;

  ptc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cal_i      (cal),
    .up_valid_i (in_i.valid),
    .up_ready_o (in_i.ready),
    .ut_i       (in_i.raw_temperature),
    .upb_i      (in_i.raw_pressure_bytes),
    .dn_valid_o (f_valid),
    .dn_ready_i (f_ready),
    .dividend_o (f_dividend),
    .divisor_o  (f_divisor),
    .side_o     (f_side)
  );

  ptc_div #(
    .NW    (ptc_pkg::D1N_W),
    .DW    (ptc_pkg::D1D_W),
    .SW    ($bits(ptc_pkg::side1_t)),
    .STEPS (DIV_STEPS)
  ) u_div_temp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (f_valid),
    .up_ready_o (f_ready),
    .dividend_i (f_dividend),
    .divisor_i  (f_divisor),
    .side_i     (f_side),
    .dn_valid_o (d1_valid),
    .dn_ready_i (d1_ready),
    .quotient_o (d1_q),
    .side_o     (d1_side)
  );

  ptc_mid u_mid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cal_i      (cal),
    .up_valid_i (d1_valid),
    .up_ready_o (d1_ready),
    .q_i        (d1_q),
    .side_i     (d1_side),
    .dn_valid_o (m_valid),
    .dn_ready_i (m_ready),
    .dividend_o (m_dividend),
    .divisor_o  (m_divisor),
    .side_o     (m_side)
  );

  ptc_div #(
    .NW    (ptc_pkg::D2N_W),
    .DW    (ptc_pkg::D2D_W),
    .SW    ($bits(ptc_pkg::side2_t)),
    .STEPS (DIV_STEPS)
  ) u_div_pres (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (m_valid),
    .up_ready_o (m_ready),
    .dividend_i (m_dividend),
    .divisor_i  (m_divisor),
    .side_i     (m_side),
    .dn_valid_o (d2_valid),
    .dn_ready_i (d2_ready),
    .quotient_o (d2_q),
    .side_o     (d2_side)
  );

  ptc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (d2_valid),
    .up_ready_o (d2_ready),
    .q_i        (d2_q),
    .side_i     (d2_side),
    .dn_valid_o (out_o.valid),
    .dn_ready_i (out_o.ready),
    .temp_o     (out_o.temperature_decideg),
    .pres_o     (out_o.pressure_pa),
    .fault_o    (out_o.divide_fault)
  );

  `PTC_ASSERT_IMPL(a_fault_zeroes, clk_i, rst_ni, out_o.valid && out_o.divide_fault, out_o.temperature_decideg == '0 && out_o.pressure_pa == '0, "faulted result carries nonzero values")
  `PTC_ASSERT_IMPL(a_drain_opens_input, clk_i, rst_ni, out_o.ready, in_i.ready, "input blocked while output drains")

endmodule

`default_nettype wire

// ===== test/ptc_checker.sv =====
`timescale 1ns / 100ps

module ptc_checker
  import ptc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  ptc_in_if    in_m,
  ptc_out_if   out_m,
  ptc_cfg_if   cfg_m,
  output int   errors_o,
  output int   pending_o
);

  typedef struct packed {
    logic signed [T_W-1:0] temp;
    logic [P_W-1:0]        press;
    logic                  fault;
  } reading_t;

  cal_t     cal;
  reading_t readings_due[$];

  function automatic longint wrap32(input longint v);
    return longint'(int'(v));
  endfunction

  function automatic reading_t compensate(input cal_t c, input logic [UT_W-1:0] ut,
                                          input logic [UPB_W-1:0] upb);
    longint   up, x1, x2, x3, den, b5, b6, sq, b3, b4, b7, p, t;
    reading_t r;
    r = '0;
    up = longint'(upb >> (8 - c.oss));
    x1 = wrap32(((longint'(ut) - longint'(c.ac6)) * longint'(c.ac5)) >>> 15);
    den = wrap32(x1 + longint'(c.md));
    if (den == 0) begin
      r.fault = 1'b1;
      return r;
    end
    x2 = wrap32((longint'(c.mc) * 2048) / den);
    b5 = wrap32(x1 + x2);
    b6 = wrap32(b5 - K_T_OFF);
    sq = wrap32((b6 * b6) >>> 12);
    x1 = wrap32((longint'(c.b2) * sq) >>> 11);
    x2 = wrap32((longint'(c.ac2) * b6) >>> 11);
    x3 = wrap32(x1 + x2);
    b3 = wrap32((wrap32(wrap32(longint'(c.ac1) * 4 + x3) << c.oss) + 2) >>> 2);
    x1 = wrap32((longint'(c.ac3) * b6) >>> 13);
    x2 = wrap32((longint'(c.b1) * sq) >>> 16);
    x3 = wrap32((x1 + x2 + 2) >>> 2);
    b4 = (longint'(c.ac4) * (x3 + K_B4_OFF)) >>> 15;
    if (b4 == 0) begin
      r.fault = 1'b1;
      return r;
    end
    b7 = (up - b3) * longint'(K_B7 >> c.oss);
    p = (b7 * 2) / b4;
    if (p > 64'sd2147483647) p = 64'sd2147483647;
    if (p < -64'sd2147483648) p = -64'sd2147483648;
    x1 = p >>> 8;
    x1 = (x1 * x1 * K_X1) >>> 16;
    x2 = (p * K_X2) >>> 16;
    p = p + ((x1 + x2 + K_COR) >>> 4);
    if (p < 0) p = 0;
    if (p > longint'(P_MAX)) p = longint'(P_MAX);
    t = b5 >>> 4;
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    r.temp = t[T_W-1:0];
    r.press = p[P_W-1:0];
    return r;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    errors_o++;
  endtask

  assign pending_o = readings_due.size();

  always @(posedge clk_i or negedge rst_ni) begin
    reading_t want;
    if (!rst_ni) begin
      cal <= '0;
      errors_o = 0;
      readings_due.delete();
    end else begin
      if (cfg_m.valid && cfg_m.ready) begin
        case (cfg_m.index)
          CFG_AC_FIRST: begin
            cal.ac1 <= cfg_m.data[47:32];
            cal.ac2 <= cfg_m.data[31:16];
            cal.ac3 <= cfg_m.data[15:0];
          end
          CFG_AC_SECOND: begin
            cal.ac4 <= cfg_m.data[47:32];
            cal.ac5 <= cfg_m.data[31:16];
            cal.ac6 <= cfg_m.data[15:0];
          end
          CFG_B_PAIR: begin
            cal.b1 <= cfg_m.data[31:16];
            cal.b2 <= cfg_m.data[15:0];
          end
          CFG_M_PAIR: begin
            cal.mc <= cfg_m.data[31:16];
            cal.md <= cfg_m.data[15:0];
          end
          CFG_OSS: cal.oss <= cfg_m.data[1:0];
          default: ;
        endcase
      end
      if (in_m.valid && in_m.ready)
        readings_due.push_back(compensate(cal, in_m.raw_temperature, in_m.raw_pressure_bytes));
      if (out_m.valid && out_m.ready) begin
        if (readings_due.size() == 0) begin
          report("unexpected transaction", 0, 0);
        end else begin
          want = readings_due.pop_front();
          if (out_m.temperature_decideg !== want.temp)
            report("temperature_decideg", out_m.temperature_decideg, want.temp);
          if (out_m.pressure_pa !== want.press)
            report("pressure_pa", out_m.pressure_pa, want.press);
          if (out_m.divide_fault !== want.fault)
            report("divide_fault", out_m.divide_fault, want.fault);
        end
      end
    end
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import ptc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 80;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   errors;
  int   pending;
  int   idle_cycles = 0;
  bit   burst = 1'b0;

  ptc_in_if  in_ch ();
  ptc_out_if out_ch ();
  ptc_cfg_if cfg_ch ();

  pressure_temp_compensation uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  ptc_checker checker_inst (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_m     (in_ch),
    .out_m    (out_ch),
    .cfg_m    (cfg_ch),
    .errors_o (errors),
    .pending_o(pending)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.raw_temperature = '0;
    in_ch.raw_pressure_bytes = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
  end

  function automatic int draw_gap();
    return burst ? 0 : $urandom_range(9, 0);
  endfunction

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  // result side stall
  initial begin
    int stall;
    wait (rst_ni);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_ch.valid && out_ch.ready));
    end
  end

  task automatic send_reading(input logic [UT_W-1:0] ut, input logic [UPB_W-1:0] upb);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.raw_temperature <= ut;
    in_ch.raw_pressure_bytes <= upb;
    do @(posedge clk_i); while (!(in_ch.valid && in_ch.ready));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    in_ch.valid <= 1'b0;
    // let the checker count a transaction accepted at the last edge
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk_i); while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_cal(input logic [15:0] ac1, ac2, ac3, ac4, ac5, ac6,
                          input logic [15:0] b1, b2, mc, md, input logic [1:0] oss);
    write_reg(CFG_AC_FIRST, {ac1, ac2, ac3});
    write_reg(CFG_AC_SECOND, {ac4, ac5, ac6});
    write_reg(CFG_B_PAIR, {16'h0, b1, b2});
    write_reg(CFG_M_PAIR, {16'h0, mc, md});
    write_reg(CFG_OSS, {46'h0, oss});
  endtask

  task automatic load_typical(input logic [1:0] oss);
    load_cal(16'd408, -16'sd72, -16'sd14383, 16'd32741, 16'd32757, 16'd23153,
             16'd6190, 16'd4, -16'sd8711, 16'd2868, oss);
  endtask

  task automatic load_random(input bit wild);
    logic [15:0] v[11];
    if (wild) begin
      foreach (v[k]) v[k] = 16'($urandom());
    end else begin
      v[0] = 16'(16'd408 + $urandom_range(200, 0) - 100);
      v[1] = 16'(-16'sd72 + $urandom_range(100, 0) - 50);
      v[2] = 16'(-16'sd14383 + $urandom_range(2000, 0) - 1000);
      v[3] = 16'(16'd32741 + $urandom_range(1000, 0) - 500);
      v[4] = 16'(16'd32757 + $urandom_range(1000, 0) - 500);
      v[5] = 16'(16'd23153 + $urandom_range(2000, 0) - 1000);
      v[6] = 16'(16'd6190 + $urandom_range(400, 0) - 200);
      v[7] = 16'($urandom_range(20, 0));
      v[8] = 16'(-16'sd8711 + $urandom_range(1000, 0) - 500);
      v[9] = 16'(16'd2868 + $urandom_range(400, 0) - 200);
    end
    load_cal(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8], v[9],
             2'($urandom_range(3, 0)));
  endtask

  initial begin
    logic [15:0] ut;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset calibration: zero divisor on the first divide
    send_reading(16'd27898, 24'h5D2300);
    send_reading(16'hFFFF, 24'hFFFFFF);

    load_typical(2'd0);
    send_reading(16'd27898, 24'd23843 << 8);
    send_reading(16'd0, 24'd0);
    send_reading(16'hFFFF, 24'hFFFFFF);
    send_reading(16'd0, 24'hFFFFFF);
    send_reading(16'hFFFF, 24'd0);
    load_typical(2'd3);
    send_reading(16'd27898, 24'h5D23A5);
    send_reading(16'hFFFF, 24'hFFFFFF);
    send_reading(16'd0, 24'd0);

    // first divisor zero: ac5 zero so x1 is zero, md zero
    load_cal(16'd408, -16'sd72, -16'sd14383, 16'd32741, 16'd0, 16'd23153,
             16'd6190, 16'd4, -16'sd8711, 16'd0, 2'd1);
    send_reading(16'd27898, 24'h5D2300);
    // second divisor zero: ac4 zero
    write_reg(CFG_AC_SECOND, {16'd0, 16'd32757, 16'd23153});
    write_reg(CFG_M_PAIR, {16'h0, -16'sd8711, 16'd2868});
    send_reading(16'd27898, 24'h5D2300);
    // extreme coefficients drive saturation paths
    load_cal(16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'h0000,
             16'h8000, 16'h7FFF, 16'h7FFF, 16'h0001, 2'd2);
    send_reading(16'hFFFF, 24'hFFFFFF);
    send_reading(16'd0, 24'd0);
    load_cal(16'h8000, 16'h7FFF, 16'h8000, 16'd1, 16'hFFFF, 16'hFFFF,
             16'h7FFF, 16'h8000, 16'h8000, 16'hFFFF, 2'd0);
    send_reading(16'd0, 24'hFFFFFF);
    send_reading(16'hFFFF, 24'd0);
    // unused index must not disturb calibration
    write_reg(CFG_UNUSED, 48'hFFFF_FFFF_FFFF);
    send_reading(16'd12345, 24'h123456);

    for (int phase = 0; phase < 8; phase++) begin
      load_random(phase % 3 == 2);
      for (int n = 0; n < 200; n++) begin
        if (n % 50 == 0) burst = ($urandom_range(3, 0) == 0);
        ut = ($urandom_range(3, 0) == 0) ? 16'($urandom()) : 16'($urandom_range(35000, 20000));
        send_reading(ut, 24'($urandom()));
      end
      burst = 1'b0;
    end
    in_ch.valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
